@@ design/ers_pkg.sv @@
// ----------------------------------------------------------------------------
// ers_pkg
// Shared constants and the per-beat pipeline record for the exponential
// range-reduction / series datapath.
// ----------------------------------------------------------------------------
package ers_pkg;

  // Field widths
  localparam int ARG_W  = 32;
  localparam int K_W    = 9;
  localparam int MANT_W = 32;
  localparam int TC_W   = 5;
  localparam int Q_W    = 64;

  // ln2 in Q0.52, rounded to nearest
  localparam logic [51:0] LN2_Q52 = 52'hB17217F7D1CF8;

  // floor(2^83 / LN2_Q52): argument * this >> 55 estimates floor(x / ln2)
  localparam logic [31:0] RECIP_LN2 = 32'((128'd1 << 83) / {76'd0, LN2_Q52});

  // 1.0 in Q2.62
  localparam logic [Q_W-1:0] ONE_Q62 = 64'h4000_0000_0000_0000;

  // Reset value of the term count register
  localparam logic [TC_W-1:0] TERM_COUNT_RST = 5'd10;

  // One beat moving down the series chain
  typedef struct packed {
    logic signed [K_W-1:0] k;     // power of two
    logic [Q_W-1:0]        r;     // reduced argument, Q.62
    logic [Q_W-1:0]        term;  // latest series term, Q.62
    logic [Q_W-1:0]        sum;   // running sum, Q.62
    logic                  add;   // term still has to be added to sum
    logic [TC_W-1:0]       n;     // terms to use for this beat
  } ers_item_t;

endpackage

@@ design/ers_mul_q62.sv @@
// ----------------------------------------------------------------------------
// ers_mul_q62
// Two-stage unsigned Q.62 multiplier: (a * b) >> 62, truncated.
// Stage one forms four 32x32 partial products, stage two sums them.
// ----------------------------------------------------------------------------
module ers_mul_q62 (
  input  logic                    clk,
  input  logic                    en,
  input  logic [ers_pkg::Q_W-1:0] a,
  input  logic [ers_pkg::Q_W-1:0] b,
  output logic [ers_pkg::Q_W-1:0] p
);

  logic [63:0]  pp_ll_r, pp_lh_r, pp_hl_r, pp_hh_r;
  logic [127:0] full;
  logic [63:0]  p_r;

  // Partial products
  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll_r <= a[31:0]  * b[31:0];
      pp_lh_r <= a[31:0]  * b[63:32];
      pp_hl_r <= a[63:32] * b[31:0];
      pp_hh_r <= a[63:32] * b[63:32];
    end
  end

  // Recombine and take bits 125:62
  assign full = {64'd0, pp_ll_r}
              + {32'd0, pp_lh_r, 32'd0}
              + {32'd0, pp_hl_r, 32'd0}
              + {pp_hh_r, 64'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= full[125:62];
    end
  end

  assign p = p_r;

endmodule

@@ design/ers_range_reduce.sv @@
// ----------------------------------------------------------------------------
// ers_range_reduce
// Three-stage split of x into k*ln2 + r with r in [0, ln2).
// Estimate k by reciprocal multiply, form the remainder, then correct by one.
// ----------------------------------------------------------------------------
module ers_range_reduce #(
  parameter int MAX_TERMS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_v,
  input  logic signed [ers_pkg::ARG_W-1:0] in_arg,
  input  logic [ers_pkg::TC_W-1:0]         term_count,
  output logic                             out_v,
  output ers_pkg::ers_item_t               out_item
);

  // Stage 1: k estimate
  logic signed [64:0]                prod;
  logic [ers_pkg::TC_W-1:0]          n_cl;
  logic                              v1_r;
  logic signed [ers_pkg::ARG_W-1:0]  x1_r;
  logic signed [ers_pkg::K_W-1:0]    k1_r;
  logic [ers_pkg::TC_W-1:0]          n1_r;

  assign prod = $signed(in_arg) * $signed({1'b0, ers_pkg::RECIP_LN2});
  assign n_cl = (32'(term_count) > MAX_TERMS) ? ers_pkg::TC_W'(MAX_TERMS) : term_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r <= in_arg;
      k1_r <= prod[63:55];  // floor via arithmetic shift, fits 9 bits
      n1_r <= n_cl;
    end
  end

  // Stage 2: remainder x*2^28 - k*ln2, within (-ln2, 2*ln2)
  logic signed [59:0]             x52;
  logic signed [61:0]             kl;
  logic signed [61:0]             rem;
  logic                           v2_r;
  logic signed [ers_pkg::K_W-1:0] k2_r;
  logic signed [53:0]             r2_r;
  logic [ers_pkg::TC_W-1:0]       n2_r;

  assign x52 = {x1_r, 28'd0};
  assign kl  = k1_r * $signed({1'b0, ers_pkg::LN2_Q52});
  assign rem = {{2{x52[59]}}, x52} - kl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k2_r <= k1_r;
      r2_r <= rem[53:0];
      n2_r <= n1_r;
    end
  end

  // Stage 3: pull the remainder into [0, ln2)
  logic signed [53:0]             ln2_w;
  logic signed [53:0]             r_up, r_dn, r_nxt;
  logic signed [ers_pkg::K_W-1:0] k_nxt;
  logic                           r_neg, r_ge;
  logic                           v3_r;
  logic signed [ers_pkg::K_W-1:0] k3_r;
  logic [51:0]                    r3_r;
  logic [ers_pkg::TC_W-1:0]       n3_r;

  assign ln2_w = $signed({2'b00, ers_pkg::LN2_Q52});
  assign r_up  = r2_r + ln2_w;
  assign r_dn  = r2_r - ln2_w;
  assign r_neg = r2_r[53];
  assign r_ge  = !r_neg && (r2_r >= ln2_w);

  always_comb begin
    if (r_neg) begin
      r_nxt = r_up;
      k_nxt = k2_r - 9'sd1;
    end else if (r_ge) begin
      r_nxt = r_dn;
      k_nxt = k2_r + 9'sd1;
    end else begin
      r_nxt = r2_r;
      k_nxt = k2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k3_r <= k_nxt;
      r3_r <= r_nxt[51:0];
      n3_r <= n2_r;
    end
  end

  // Seed the series: term = sum = 1.0, r moved to Q.62
  assign out_v         = v3_r;
  assign out_item.k    = k3_r;
  assign out_item.r    = {2'b00, r3_r, 10'd0};
  assign out_item.term = ers_pkg::ONE_Q62;
  assign out_item.sum  = ers_pkg::ONE_Q62;
  assign out_item.add  = 1'b0;
  assign out_item.n    = n3_r;

endmodule

@@ design/ers_term.sv @@
// ----------------------------------------------------------------------------
// ers_term
// One series step, four stages: step = r * (1/IDX), term = term * step.
// Folds the previous pending term into the sum on entry.
// ----------------------------------------------------------------------------
module ers_term #(
  parameter int IDX = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_v,
  input  ers_pkg::ers_item_t in_item,
  output logic               out_v,
  output ers_pkg::ers_item_t out_item
);

  localparam logic [ers_pkg::Q_W-1:0] RECIP = 64'((64'd1 << 62) / 64'(IDX));

  logic [ers_pkg::Q_W-1:0] step;
  logic [ers_pkg::Q_W-1:0] term_new;
  logic                    use_term;
  ers_pkg::ers_item_t      item_nxt;
  ers_pkg::ers_item_t      it_a_r, it_b_r, it_c_r, it_d_r;
  logic                    v_a_r, v_b_r, v_c_r, v_d_r;

  // Accumulate the pending term from the previous step
  always_comb begin
    item_nxt = in_item;
    if (in_item.add) begin
      item_nxt.sum = in_item.sum + in_item.term;
    end
    item_nxt.add = 1'b0;
  end

  // step = r / IDX, ready alongside it_b_r
  ers_mul_q62 u_mul_step (
    .clk (clk),
    .en  (en),
    .a   (in_item.r),
    .b   (RECIP),
    .p   (step)
  );

  // term * step, ready alongside it_d_r
  ers_mul_q62 u_mul_term (
    .clk (clk),
    .en  (en),
    .a   (it_b_r.term),
    .b   (step),
    .p   (term_new)
  );

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
    end else if (en) begin
      v_a_r <= in_v;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
      v_d_r <= v_c_r;
    end
  end

  // Sideband delay matching the two multipliers
  always_ff @(posedge clk) begin
    if (en) begin
      it_a_r <= item_nxt;
      it_b_r <= it_a_r;
      it_c_r <= it_b_r;
      it_d_r <= it_c_r;
    end
  end

  // Only steps up to n contribute
  assign use_term = (IDX <= 32'(it_d_r.n));

  always_comb begin
    out_item = it_d_r;
    if (use_term) begin
      out_item.term = term_new;
      out_item.add  = 1'b1;
    end
  end

  assign out_v = v_d_r;

endmodule

@@ design/exp_range_reduced_series.sv @@
// ----------------------------------------------------------------------------
// exp_range_reduced_series
// e^x for a signed Q8.24 argument as 2^k times a Q1.31 mantissa.
// ----------------------------------------------------------------------------
// One argument per clock while in_ready is high, fully pipelined. The path
// has three stages of range reduction (reciprocal multiply, remainder,
// correction), four per series term (two two-stage 64-bit multipliers
// built from 32x32 partial products), and the output register that adds
// the last term and saturates. Every beat uses min(term_count,
// MAX_TERMS) series terms; term_count is meant to be written while no beat
// is in flight. in_ready drops only while the output register holds an
// untaken result and the last pipeline stage is also occupied; the whole
// pipeline then holds.
// ----------------------------------------------------------------------------
module exp_range_reduced_series #(
  parameter int MAX_TERMS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // argument channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [ers_pkg::ARG_W-1:0] in_argument,
  // result channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [ers_pkg::K_W-1:0]   out_exponent_k,
  output logic [ers_pkg::MANT_W-1:0]       out_mantissa,
  // configuration
  input  logic                             cfg_we,
  input  logic [ers_pkg::TC_W-1:0]         cfg_term_count
);

  // Term count register
  logic [ers_pkg::TC_W-1:0] term_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_count_r <= ers_pkg::TERM_COUNT_RST;
    end else if (cfg_we) begin
      term_count_r <= cfg_term_count;
    end
  end

  // Pipeline advance: move unless the last stage is full and the output is stuck
  logic pipe_adv;
  logic out_load;
  logic chain_v [0:MAX_TERMS];
  ers_pkg::ers_item_t chain_item [0:MAX_TERMS];

  assign out_load = !out_valid || out_ready;
  assign pipe_adv = !chain_v[MAX_TERMS] || !out_valid || out_ready;
  assign in_ready = pipe_adv;

  // Range reduction
  ers_range_reduce #(
    .MAX_TERMS (MAX_TERMS)
  ) u_range (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (pipe_adv),
    .in_v       (in_valid),
    .in_arg     (in_argument),
    .term_count (term_count_r),
    .out_v      (chain_v[0]),
    .out_item   (chain_item[0])
  );

  // Series chain, one unit per term
  for (genvar gi = 1; gi <= MAX_TERMS; gi++) begin : g_term
    ers_term #(
      .IDX (gi)
    ) u_term (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (pipe_adv),
      .in_v     (chain_v[gi-1]),
      .in_item  (chain_item[gi-1]),
      .out_v    (chain_v[gi]),
      .out_item (chain_item[gi])
    );
  end

  // Final accumulate and saturate into the output register
  logic [ers_pkg::Q_W-1:0]        sum_fin;
  logic [ers_pkg::MANT_W-1:0]     mant_nxt;
  logic                           out_valid_r;
  logic signed [ers_pkg::K_W-1:0] out_k_r;
  logic [ers_pkg::MANT_W-1:0]     out_mant_r;

  assign sum_fin  = chain_item[MAX_TERMS].add
                  ? chain_item[MAX_TERMS].sum + chain_item[MAX_TERMS].term
                  : chain_item[MAX_TERMS].sum;
  assign mant_nxt = sum_fin[63] ? '1 : sum_fin[62:31];

  // Output valid holds an untaken beat even while the chain moves below it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= chain_v[MAX_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_adv && chain_v[MAX_TERMS]) begin
      out_k_r    <= chain_item[MAX_TERMS].k;
      out_mant_r <= mant_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_exponent_k = out_k_r;
  assign out_mantissa   = out_mant_r;

`ifndef SYNTHESIS
  // Mantissa always lies in [1, 2)
  a_mant_norm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_mantissa[31])
    else $error("mantissa below 1.0");

  // Exponent stays inside the reachable range
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_exponent_k >= -9'sd185 && out_exponent_k <= 9'sd185))
    else $error("exponent out of range");

  // Input is held off only by a stalled, occupied output
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");
`endif

endmodule
